[src/rls_pkg.sv]
// ----------------------------------------------------------------------------
// rls_pkg
// Shared widths, constants and types of the random looping shift register.
// ----------------------------------------------------------------------------
package rls_pkg;

    // Looping register and delay line
    localparam int LEN_MAX    = 32;
    localparam int LEN_W      = $clog2(LEN_MAX + 1);
    localparam int LEN_IDX_W  = $clog2(LEN_MAX);
    localparam int DELAY_MAX  = 15;
    localparam int HIST_IDX_W = $clog2(DELAY_MAX);

    // Field widths
    localparam int SMP_W     = 12;
    localparam int RND_W     = 7;
    localparam int CV_W      = 12;
    localparam int STEP_W    = 8;
    localparam int SEQ_W     = 16;
    localparam int NUM_LVL   = 8;
    localparam int NUM_TAP   = 4;
    localparam int MASK_W    = 32;
    localparam int CFG_LEN_W = 6;
    localparam int CFG_DLY_W = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REG_LEN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_OR_TRIG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_AND_TRIG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_OR_GATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_AND_GATE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_SEQ_EN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_SCALE_EN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REG_CV_DELAY  = 3'd7;

    localparam logic [CFG_LEN_W-1:0] CFG_LEN_RESET = 6'd16;

    // Tap slots
    localparam int TAP_OR_TRIG  = 0;
    localparam int TAP_AND_TRIG = 1;
    localparam int TAP_OR_GATE  = 2;
    localparam int TAP_AND_GATE = 3;

    // Flip factor: control / 34, via reciprocal 7711 / 2^18 (exact for 12 bits)
    localparam int FAC_W      = 7;
    localparam int FAC_M_W    = 13;
    localparam int FAC_SH     = 18;
    localparam int FAC_PROD_W = SMP_W + FAC_M_W;
    localparam logic [FAC_M_W-1:0] FAC_M    = 13'd7711;
    localparam logic [SMP_W-1:0]   DEAD_LO  = 12'd1700;
    localparam logic [SMP_W-1:0]   DEAD_HI  = 12'd1800;
    localparam logic [FAC_W-1:0]   FAC_MID  = 7'd50;
    localparam logic [FAC_W-1:0]   FAC_ALL  = 7'd100;

    // Sequencer arithmetic
    localparam int SUM_W    = SMP_W + $clog2(NUM_LVL);
    localparam int SEQ_SH   = 12;
    localparam int DIV_X_W  = 28;
    localparam int DIV_C_W  = 12;
    localparam int DIV_SH   = 28;
    localparam int DIV_M_W  = 17;
    localparam int DIV_P_W  = DIV_X_W + DIV_M_W;
    localparam logic [DIV_C_W-1:0] DIV_C = 12'd3500;
    localparam logic [DIV_M_W-1:0] DIV_M = 17'd76695;

    // Pipeline stages from the accepting edge up to the output register
    localparam int PIPE_N   = 9;
    localparam int STG_DIV1 = 4;
    localparam int STG_LAST = PIPE_N - 1;

    typedef struct packed {
        logic en;
        logic keep;
    } t_cell_ctl;

    typedef struct packed {
        logic [CV_W-1:0]    cv;
        logic [CV_W-1:0]    dly;
        logic [STEP_W-1:0]  step;
        logic [NUM_TAP-1:0] tap;
        logic [SMP_W-1:0]   scale;
    } t_side;

endpackage

[src/rls_in_if.sv]
// ----------------------------------------------------------------------------
// rls_in_if
// Input channel: one clock step with its control, random and level samples.
// ----------------------------------------------------------------------------
interface rls_in_if import rls_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] control_sample;
    logic [RND_W-1:0] random_value;
    logic [SMP_W-1:0] scale_sample;
    logic [SMP_W-1:0] level_0;
    logic [SMP_W-1:0] level_1;
    logic [SMP_W-1:0] level_2;
    logic [SMP_W-1:0] level_3;
    logic [SMP_W-1:0] level_4;
    logic [SMP_W-1:0] level_5;
    logic [SMP_W-1:0] level_6;
    logic [SMP_W-1:0] level_7;

    modport source (
        output valid, control_sample, random_value, scale_sample,
        output level_0, level_1, level_2, level_3,
        output level_4, level_5, level_6, level_7,
        input  ready
    );

    modport sink (
        input  valid, control_sample, random_value, scale_sample,
        input  level_0, level_1, level_2, level_3,
        input  level_4, level_5, level_6, level_7,
        output ready
    );

endinterface

[src/rls_out_if.sv]
// ----------------------------------------------------------------------------
// rls_out_if
// Output channel: CVs, step bits, logic taps and sequencer CV of one step.
// ----------------------------------------------------------------------------
interface rls_out_if import rls_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CV_W-1:0]   cv_value;
    logic [CV_W-1:0]   delayed_cv;
    logic [STEP_W-1:0] step_bits;
    logic              trig_or;
    logic              trig_and;
    logic              gate_or;
    logic              gate_and;
    logic [SEQ_W-1:0]  sequencer_cv;

    modport source (
        output valid, cv_value, delayed_cv, step_bits,
        output trig_or, trig_and, gate_or, gate_and, sequencer_cv,
        input  ready
    );

    modport sink (
        input  valid, cv_value, delayed_cv, step_bits,
        input  trig_or, trig_and, gate_or, gate_and, sequencer_cv,
        output ready
    );

endinterface

[src/rls_cell.sv]
// ----------------------------------------------------------------------------
// rls_cell
// One bit of the looping register; takes its neighbor's bit on each step.
// ----------------------------------------------------------------------------
module rls_cell import rls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_din,
    output logic      o_bit,
    output logic      o_next
);

    logic r_bit;
    logic n_bit;

    // clear positions past the active length
    assign n_bit = i_ctl.keep ? i_din : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.en) begin
            r_bit <= n_bit;
        end
    end

    assign o_bit  = r_bit;
    assign o_next = n_bit;

endmodule

[src/rls_div3500.sv]
// ----------------------------------------------------------------------------
// rls_div3500
// Three-stage floor division by 3500: reciprocal multiply, then one fixup.
// ----------------------------------------------------------------------------
module rls_div3500 import rls_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [DIV_X_W-1:0] i_x,
    output logic [SEQ_W-1:0]   o_q
);

    logic [DIV_P_W-1:0] r_p;
    logic [DIV_X_W-1:0] r_x1;
    logic [DIV_M_W-1:0] r_q0;
    logic [DIV_X_W-1:0] r_t;
    logic [DIV_X_W-1:0] r_x2;
    logic [SEQ_W-1:0]   r_q;

    logic [DIV_M_W-1:0] w_q0;
    logic [DIV_X_W-1:0] w_rem;

    // estimate is exact or one low
    assign w_q0  = r_p[DIV_SH +: DIV_M_W];
    assign w_rem = r_x2 - r_t;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= DIV_P_W'(i_x) * DIV_P_W'(DIV_M);
            r_x1 <= i_x;
            r_q0 <= w_q0;
            r_t  <= DIV_X_W'(DIV_X_W'(w_q0) * DIV_X_W'(DIV_C));
            r_x2 <= r_x1;
            if (w_rem >= DIV_X_W'(DIV_C)) begin
                r_q <= SEQ_W'(r_q0 + DIV_M_W'(1));
            end else begin
                r_q <= SEQ_W'(r_q0);
            end
        end
    end

    assign o_q = r_q;

endmodule

[src/random_looping_shift_register.sv]
// ----------------------------------------------------------------------------
// random_looping_shift_register
// Looping bit register with random flips, CV taps, logic taps and sequencer.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not stalled; the loop cells
//   update on each accepted beat and the sequencer path is a 9-stage pipeline
//   through two divide-by-3500 units.
// Output stalls hold the whole pipeline in place.
// Reset (synchronous, active low): loop cells, CV history, held logic and
//   sequencer outputs clear to zero; configuration returns to its defaults.
// ----------------------------------------------------------------------------
module random_looping_shift_register import rls_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rls_in_if.sink                i_in,
    rls_out_if.source             o_out
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_LEN_W-1:0] r_cfg_len;
    logic [MASK_W-1:0]    r_cfg_mask [NUM_TAP];
    logic                 r_cfg_seq_en;
    logic                 r_cfg_scale_en;
    logic [CFG_DLY_W-1:0] r_cfg_dly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len      <= CFG_LEN_RESET;
            r_cfg_mask     <= '{default: '0};
            r_cfg_seq_en   <= 1'b0;
            r_cfg_scale_en <= 1'b0;
            r_cfg_dly      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REG_LEN: begin
                    r_cfg_len <= i_cfg_data[CFG_LEN_W-1:0];
                end
                CFG_REG_OR_TRIG: begin
                    r_cfg_mask[TAP_OR_TRIG] <= i_cfg_data[MASK_W-1:0];
                end
                CFG_REG_AND_TRIG: begin
                    r_cfg_mask[TAP_AND_TRIG] <= i_cfg_data[MASK_W-1:0];
                end
                CFG_REG_OR_GATE: begin
                    r_cfg_mask[TAP_OR_GATE] <= i_cfg_data[MASK_W-1:0];
                end
                CFG_REG_AND_GATE: begin
                    r_cfg_mask[TAP_AND_GATE] <= i_cfg_data[MASK_W-1:0];
                end
                CFG_REG_SEQ_EN: begin
                    r_cfg_seq_en <= i_cfg_data[0];
                end
                CFG_REG_SCALE_EN: begin
                    r_cfg_scale_en <= i_cfg_data[0];
                end
                CFG_REG_CV_DELAY: begin
                    r_cfg_dly <= i_cfg_data[CFG_DLY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: advance every stage when the output register can move
    // ------------------------------------------------------------------
    logic w_adv;
    logic w_acc;

    assign w_adv      = !o_out.valid || o_out.ready;
    assign w_acc      = i_in.valid && w_adv;
    assign i_in.ready = w_adv;

    // ------------------------------------------------------------------
    // Flip decision: factor is control/34 outside the dead zone, else 50
    // ------------------------------------------------------------------
    logic [FAC_PROD_W-1:0] w_fac_prod;
    logic [FAC_W-1:0]      w_fac;
    logic                  w_negate;

    assign w_fac_prod = FAC_PROD_W'(i_in.control_sample) * FAC_PROD_W'(FAC_M);

    always_comb begin
        if (i_in.control_sample >= DEAD_LO && i_in.control_sample <= DEAD_HI) begin
            w_fac = FAC_MID;
        end else begin
            w_fac = w_fac_prod[FAC_SH +: FAC_W];
        end
        if (w_fac == '0) begin
            w_negate = 1'b0;
        end else if (w_fac == FAC_ALL) begin
            w_negate = 1'b1;
        end else begin
            w_negate = (FAC_W'(i_in.random_value) <= w_fac);
        end
    end

    // ------------------------------------------------------------------
    // Loop cells: clamp length to 1..LEN_MAX, wrap the last bit to the front
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]     w_len;
    logic [LEN_IDX_W-1:0] w_last_idx;
    logic                 w_wrap;
    logic [LEN_MAX-1:0]   w_bit;
    logic [LEN_MAX-1:0]   w_nxt;
    t_cell_ctl            w_ctl [LEN_MAX];

    always_comb begin
        if (r_cfg_len == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(r_cfg_len) > LEN_MAX) begin
            w_len = LEN_W'(LEN_MAX);
        end else begin
            w_len = LEN_W'(r_cfg_len);
        end
    end

    assign w_last_idx = LEN_IDX_W'(w_len - LEN_W'(1));
    assign w_wrap     = w_bit[w_last_idx] ^ w_negate;

    for (genvar g = 0; g < LEN_MAX; g++) begin : g_cell
        logic w_din;

        if (g == 0) begin : g_head
            assign w_din = w_wrap;
        end else begin : g_body
            assign w_din = w_bit[g-1];
        end

        assign w_ctl[g].en   = w_acc;
        assign w_ctl[g].keep = (LEN_W'(g) < w_len);

        rls_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_din   (w_din),
            .o_bit   (w_bit[g]),
            .o_next  (w_nxt[g])
        );
    end

    // ------------------------------------------------------------------
    // Step values taken from the rotated register
    // ------------------------------------------------------------------
    logic [CV_W-1:0]    w_cv;
    logic [CV_W-1:0]    w_dly;
    logic [MASK_W-1:0]  w_tap_bits;
    logic [NUM_TAP-1:0] w_tap;
    logic [SMP_W-1:0]   w_lvl [NUM_LVL];

    // first register bit lands in the CV's most significant bit
    always_comb begin
        for (int k = 0; k < CV_W; k++) begin
            w_cv[CV_W-1-k] = w_nxt[k];
        end
    end

    assign w_tap_bits = MASK_W'(w_nxt);

    assign w_tap[TAP_OR_TRIG]  = |(w_tap_bits & r_cfg_mask[TAP_OR_TRIG]);
    assign w_tap[TAP_AND_TRIG] =
        ((w_tap_bits & r_cfg_mask[TAP_AND_TRIG]) == r_cfg_mask[TAP_AND_TRIG]);
    assign w_tap[TAP_OR_GATE]  = |(w_tap_bits & r_cfg_mask[TAP_OR_GATE]);
    assign w_tap[TAP_AND_GATE] =
        ((w_tap_bits & r_cfg_mask[TAP_AND_GATE]) == r_cfg_mask[TAP_AND_GATE]);

    assign w_lvl[0] = i_in.level_0;
    assign w_lvl[1] = i_in.level_1;
    assign w_lvl[2] = i_in.level_2;
    assign w_lvl[3] = i_in.level_3;
    assign w_lvl[4] = i_in.level_4;
    assign w_lvl[5] = i_in.level_5;
    assign w_lvl[6] = i_in.level_6;
    assign w_lvl[7] = i_in.level_7;

    // ------------------------------------------------------------------
    // CV history: newest at entry 0; a delay of zero shows the current CV
    // ------------------------------------------------------------------
    logic [CV_W-1:0] r_hist [DELAY_MAX];

    always_comb begin
        if (r_cfg_dly == '0) begin
            w_dly = w_cv;
        end else begin
            w_dly = r_hist[HIST_IDX_W'(r_cfg_dly - CFG_DLY_W'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '{default: '0};
        end else if (w_acc) begin
            r_hist[0] <= w_cv;
            for (int k = 1; k < DELAY_MAX; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valids and sideband
    // ------------------------------------------------------------------
    logic [PIPE_N-1:0] r_vld;
    t_side             r_side [PIPE_N];
    t_side             w_side_in;

    assign w_side_in.cv    = w_cv;
    assign w_side_in.dly   = w_dly;
    assign w_side_in.step  = w_nxt[STEP_W-1:0];
    assign w_side_in.tap   = w_tap;
    assign w_side_in.scale = i_in.scale_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_N-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_side_in;
            for (int k = 1; k < PIPE_N; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: gate levels by step bits, sum, scale by 4096/3500,
    // then by scale/3500 (or 3500/3500 when scaling is off)
    // ------------------------------------------------------------------
    logic [SMP_W-1:0]   r_lvl [NUM_LVL];
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   w_sum;
    logic [SEQ_W-1:0]   w_q1;
    logic [SEQ_W-1:0]   w_q2;
    logic [DIV_C_W-1:0] w_mult;
    logic [DIV_X_W-1:0] r_x2;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NUM_LVL; k++) begin
            w_sum = w_sum + SUM_W'(r_lvl[k]);
        end
    end

    assign w_mult = r_cfg_scale_en ? r_side[STG_DIV1].scale : DIV_C;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NUM_LVL; k++) begin
                r_lvl[k] <= w_nxt[k] ? w_lvl[k] : '0;
            end
            r_sum <= w_sum;
            r_x2  <= DIV_X_W'(DIV_X_W'(w_q1) * DIV_X_W'(w_mult));
        end
    end

    rls_div3500 u_div_norm (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (DIV_X_W'(r_sum) << SEQ_SH),
        .o_q   (w_q1)
    );

    rls_div3500 u_div_scale (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (r_x2),
        .o_q   (w_q2)
    );

    // ------------------------------------------------------------------
    // Output register: logic taps hold while their mask has under two bits,
    // the sequencer CV holds while disabled
    // ------------------------------------------------------------------
    logic                r_out_vld;
    logic [CV_W-1:0]     r_out_cv;
    logic [CV_W-1:0]     r_out_dly;
    logic [STEP_W-1:0]   r_out_step;
    logic [NUM_TAP-1:0]  r_out_tap;
    logic [SEQ_W-1:0]    r_out_seq;
    logic [NUM_TAP-1:0]  w_multi;

    for (genvar t = 0; t < NUM_TAP; t++) begin : g_multi
        assign w_multi[t] = |(r_cfg_mask[t] & (r_cfg_mask[t] - MASK_W'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_out_tap <= '0;
            r_out_seq <= '0;
        end else if (w_adv) begin
            r_out_vld <= r_vld[STG_LAST];
            if (r_vld[STG_LAST]) begin
                for (int t = 0; t < NUM_TAP; t++) begin
                    if (w_multi[t]) begin
                        r_out_tap[t] <= r_side[STG_LAST].tap[t];
                    end
                end
                if (r_cfg_seq_en) begin
                    r_out_seq <= w_q2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_vld[STG_LAST]) begin
            r_out_cv   <= r_side[STG_LAST].cv;
            r_out_dly  <= r_side[STG_LAST].dly;
            r_out_step <= r_side[STG_LAST].step;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.cv_value     = r_out_cv;
    assign o_out.delayed_cv   = r_out_dly;
    assign o_out.step_bits    = r_out_step;
    assign o_out.trig_or      = r_out_tap[TAP_OR_TRIG];
    assign o_out.trig_and     = r_out_tap[TAP_AND_TRIG];
    assign o_out.gate_or      = r_out_tap[TAP_OR_GATE];
    assign o_out.gate_and     = r_out_tap[TAP_AND_GATE];
    assign o_out.sequencer_cv = r_out_seq;

endmodule
